// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL: implication checks on clk, off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds in the cycle after.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/qbs_pkg.sv =====
// Package for the queued beep sequencer: queue sizing, field widths, command codes.
package qbs_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int SLOT_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int SUM_W       = SLOT_W + 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int FUNC_W      = 1;
    localparam int LEN_W       = 8;
    localparam int QCOUNT_W    = 4;
    localparam int TICK_W      = LEN_W + 1;

    localparam logic [FUNC_W-1:0] FUNC_TICK    = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_ENQUEUE = 1'b1;

endpackage

// ===== src/qbs_cmd_if.sv =====
// Command channel: tick or enqueue transactions with a beep length.
interface qbs_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [qbs_pkg::FUNC_W-1:0]  func;
    logic [qbs_pkg::LEN_W-1:0]   beep_length;

    modport source (output valid, output func, output beep_length, input ready);
    modport sink   (input valid, input func, input beep_length, output ready);
endinterface

// ===== src/qbs_rsp_if.sv =====
// Response channel: buzzer level, queue fill and drop flag after each command.
interface qbs_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          sounding;
    logic [qbs_pkg::QCOUNT_W-1:0]  queue_count;
    logic                          dropped;

    modport source (output valid, output sounding, output queue_count, output dropped,
                    input ready);
    modport sink   (input valid, input sounding, input queue_count, input dropped,
                    output ready);
endinterface

// ===== src/queued_beep_sequencer.sv =====
// Top level of the queued beep sequencer: length queue memory, phase control, response register.
//
// Queued beep sequencer. Each command transaction is either an enqueue of a beep
// length or one period tick, and each one yields exactly one response transaction
// carrying the buzzer level, the queue fill and a drop flag. Beep lengths live in a
// QUEUE_DEPTH-entry ring memory with a registered synchronous read. An enqueue only
// writes that memory, so its response is registered on acceptance. A tick has to
// read the head entry's length first: the read is launched on the accepting
// edge and the phase update lands on the next edge. Commands are taken one at a
// time; a finished response sits in an output register and a new command can be
// accepted on the same edge that response is taken. A beep at length L sounds for
// L+1 ticks, then stays silent for L+1 ticks before its entry is popped. Enqueues
// to a full queue are discarded with dropped set. The memory needs no clearing: the
// head entry is always written before a tick can read it.
module queued_beep_sequencer (
    input  logic      clk,
    input  logic      rst_n,
    qbs_cmd_if.sink   cmd,
    qbs_rsp_if.source rsp
);
    import qbs_pkg::*;

    `include "assert_macros.svh"

    typedef enum logic {
        S_IDLE,
        S_TICK
    } state_t;

    typedef enum logic [1:0] {
        PH_OFF      = 2'd0,
        PH_ON       = 2'd1,
        PH_COOLDOWN = 2'd2,
        PH_SPARE    = 2'd3
    } phase_t;

    // ring memory of beep lengths
    logic [LEN_W-1:0] length_mem [QUEUE_DEPTH];
    logic [LEN_W-1:0] rd_len_reg;

    state_t              state_reg,     state_next;
    phase_t              phase_reg,     phase_next;
    logic [SLOT_W-1:0]   head_reg,      head_next;
    logic [CNT_W-1:0]    count_reg,     count_next;
    logic [TICK_W-1:0]   tick_reg,      tick_next;
    logic                out_valid_reg, out_valid_next;
    logic                buzzer_reg,    buzzer_next;
    logic [QCOUNT_W-1:0] qcount_reg,    qcount_next;
    logic                dropped_reg,   dropped_next;

    logic                cmd_fire;
    logic                rsp_fire;
    logic                full;
    logic                wr_en;
    logic [SLOT_W-1:0]   wr_addr;
    logic [SUM_W-1:0]    tail_sum;
    logic [TICK_W-1:0]   tick_inc;
    logic [SLOT_W-1:0]   head_inc;
    logic [CNT_W-1:0]    count_dec;

    assign cmd_fire  = cmd.valid && cmd.ready;
    assign rsp_fire  = rsp.valid && rsp.ready;
    assign cmd.ready = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);

    assign rsp.valid       = out_valid_reg;
    assign rsp.sounding    = buzzer_reg;
    assign rsp.queue_count = qcount_reg;
    assign rsp.dropped     = dropped_reg;

    assign full = (count_reg == CNT_W'(QUEUE_DEPTH));

    // tail slot = (head + count) mod depth; sum stays below twice the depth
    assign tail_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign wr_addr  = (tail_sum >= SUM_W'(QUEUE_DEPTH))
                    ? SLOT_W'(tail_sum - SUM_W'(QUEUE_DEPTH))
                    : SLOT_W'(tail_sum);

    assign tick_inc  = tick_reg + TICK_W'(1);
    assign head_inc  = (head_reg == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + SLOT_W'(1);
    assign count_dec = (count_reg != '0) ? count_reg - CNT_W'(1) : count_reg;

    assign wr_en = (state_reg == S_IDLE) && cmd_fire && (cmd.func == FUNC_ENQUEUE) && !full;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        tick_next      = tick_reg;
        out_valid_next = out_valid_reg && !rsp_fire;
        dropped_next   = dropped_reg;
        buzzer_next    = buzzer_reg;
        qcount_next    = qcount_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    if (cmd.func == FUNC_ENQUEUE)
                    begin
                        if (!full)
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                        dropped_next   = full;
                        out_valid_next = 1'b1;
                        buzzer_next    = (phase_reg == PH_ON);
                        qcount_next    = QCOUNT_W'(count_next);
                    end
                    else
                    begin
                        // head length read is in flight
                        state_next = S_TICK;
                    end
                end
            end
            S_TICK:
            begin
                if (phase_reg == PH_OFF)
                begin
                    if (count_reg != '0)
                    begin
                        phase_next = PH_ON;
                        tick_next  = '0;
                    end
                end
                else
                begin
                    tick_next = tick_inc;
                    if (tick_inc > TICK_W'(rd_len_reg))
                    begin
                        if (phase_reg == PH_ON)
                        begin
                            phase_next = PH_COOLDOWN;
                            tick_next  = '0;
                        end
                        else
                        begin
                            // cooldown done: pop the head
                            head_next  = head_inc;
                            count_next = count_dec;
                            if (count_dec != '0)
                            begin
                                phase_next = PH_ON;
                                tick_next  = '0;
                            end
                            else
                            begin
                                phase_next = PH_OFF;
                            end
                        end
                    end
                end
                out_valid_next = 1'b1;
                dropped_next   = 1'b0;
                buzzer_next    = (phase_next == PH_ON);
                qcount_next    = QCOUNT_W'(count_next);
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_OFF;
            head_reg      <= '0;
            count_reg     <= '0;
            tick_reg      <= '0;
            out_valid_reg <= 1'b0;
            buzzer_reg    <= 1'b0;
            qcount_reg    <= '0;
            dropped_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            tick_reg      <= tick_next;
            out_valid_reg <= out_valid_next;
            buzzer_reg    <= buzzer_next;
            qcount_reg    <= qcount_next;
            dropped_reg   <= dropped_next;
        end
    end

    // length memory: one write port, one registered read of the head slot
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            length_mem[wr_addr] <= cmd.beep_length;
        end
        rd_len_reg <= length_mem[head_reg];
    end

    `ASSERT_IMPLY(a_count_bound, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH),
        "queue count above depth")
    `ASSERT_IMPLY(a_active_needs_entry, phase_reg != PH_OFF, count_reg != '0,
        "buzzer phase active with empty queue")
    `ASSERT_IMPLY(a_tick_slot_free, state_reg == S_TICK, !out_valid_reg,
        "tick result would overwrite a pending response")
    `ASSERT_NEXT(a_full_drops, cmd_fire && (cmd.func == FUNC_ENQUEUE) && full,
        out_valid_reg && dropped_reg && (count_reg == CNT_W'(QUEUE_DEPTH)),
        "enqueue to full queue not flagged as dropped")
    `ASSERT_IMPLY(a_tick_bound, 1'b1, tick_reg <= TICK_W'(1 << LEN_W),
        "tick count past longest period")

endmodule
